// File: hdl/assert_macros.svh
// shared assertion macros for the converter checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_HOLDS(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("converter check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("converter check failed");

`endif

// File: hdl/itp_pkg.sv
package itp_pkg;

  // characters with a role in the conversion
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_UNBAL    = 2'd2
  } status_e;

  // classification of the current character against the stack top
  typedef struct packed {
    logic operand;
    logic open;
    logic close;
    logic pop;
  } cls_t;

  // precedence rank, lowest rank stands for "not an operator"
  function automatic logic [1:0] prec_rank(logic [7:0] c);
    logic [1:0] r;
    priority if (c == CH_CARET)                    r = 2'd3;
    else if ((c == CH_STAR) || (c == CH_SLASH))    r = 2'd2;
    else if ((c == CH_PLUS) || (c == CH_MINUS))    r = 2'd1;
    else                                           r = 2'd0;
    return r;
  endfunction

  // reversed text has its parentheses turned around
  function automatic logic [7:0] swap_paren(logic [7:0] c);
    logic [7:0] r;
    priority if (c == CH_OPEN)       r = CH_CLOSE;
    else if (c == CH_CLOSE)          r = CH_OPEN;
    else                             r = c;
    return r;
  endfunction

endpackage

// File: hdl/itp_ram.sv
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/itp_prec_unit.sv
module itp_prec_unit import itp_pkg::*; (
  input  logic [7:0] cur_i,
  input  logic [7:0] top_i,
  output cls_t       cls_o
);

  logic [1:0] cur_rank;
  logic [1:0] top_rank;

  assign cur_rank = prec_rank(cur_i);
  assign top_rank = prec_rank(top_i);

  // letters and digits pass straight to the output
  assign cls_o.operand = ((cur_i >= 8'h61) && (cur_i <= 8'h7A)) ||
                         ((cur_i >= 8'h41) && (cur_i <= 8'h5A)) ||
                         ((cur_i >= 8'h30) && (cur_i <= 8'h39));
  assign cls_o.open    = (cur_i == CH_OPEN);
  assign cls_o.close   = (cur_i == CH_CLOSE);

  // right-assoc caret also pops on equal rank
  assign cls_o.pop = (cur_i == CH_CARET) ? (cur_rank <= top_rank) : (cur_rank < top_rank);

endmodule

// File: hdl/infix_to_prefix_converter_unit.sv
// channel   | dir | beat contents
// s_axis    | in  | tdata: in_char[7:0]; tlast: in_last
// m_axis    | out | tdata: out_char[7:0]; tlast: out_last; tuser: status[1:0]
//
// each input beat up to MAX_LEN is stored as it is accepted; ready drops after a last beat
// conversion: the text is walked backwards inside a wrap pair of parens; a stored char is
// read (S_NEXT, S_LATCH) and classified (S_CHAR); operators and close parens then go to S_TOP,
// which waits on the registered stack memory read and pops one entry per visit
// results: a finishing check, then per output character a memory read and a send, or 1 error beat
// reset clears control state only; a stalled result beat holds the sequencer
module infix_to_prefix_converter_unit import itp_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // in_char[7:0]
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_char[7:0]
  output logic       m_axis_tlast,
  output logic [1:0] m_axis_tuser    // status[1:0]
);

  localparam int AW  = $clog2(MAX_LEN);
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int SAW = $clog2(MAX_LEN + 1);
  localparam int SPW = $clog2(MAX_LEN + 2);
  localparam int PW  = $clog2(MAX_LEN + 3);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NEXT   = 4'd1;
  localparam logic [3:0] S_LATCH  = 4'd2;
  localparam logic [3:0] S_CHAR   = 4'd3;
  localparam logic [3:0] S_TOP    = 4'd4;
  localparam logic [3:0] S_FINISH = 4'd5;
  localparam logic [3:0] S_ORD    = 4'd6;
  localparam logic [3:0] S_OWR    = 4'd7;
  localparam logic [3:0] S_ERR    = 4'd8;

  logic [3:0]     state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           ovf_q, ovf_d;
  logic [PW-1:0]  p_q, p_d;
  logic [SPW-1:0] sp_q, sp_d;
  logic [CW-1:0]  oc_q, oc_d;
  logic [AW-1:0]  ridx_q, ridx_d;
  logic [7:0]     c_q, c_d;
  status_e        err_q, err_d;
  logic           ov_q, ov_d;
  logic [7:0]     od_q, od_d;
  logic           ol_q, ol_d;
  logic [1:0]     ou_q, ou_d;

  logic           s_fire;
  logic           out_free;
  logic           in_we;
  logic [AW-1:0]  in_raddr;
  logic [7:0]     in_rdata;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [SAW-1:0] stk_raddr;
  logic [7:0]     stk_rdata;
  logic           out_we;
  logic [7:0]     out_wdata;
  logic [7:0]     out_rdata;
  logic           load_out;
  logic [PW-1:0]  n_ext;
  cls_t           cls;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ov_q || m_axis_tready;
  assign n_ext         = PW'(cnt_q);
  assign in_raddr      = AW'(n_ext - p_q);

  // character store, stack and output store
  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (in_we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (in_raddr),
    .rdata_o (in_rdata)
  );

  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN + 1)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (c_q),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  itp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (out_we),
    .waddr_i (oc_q[AW-1:0]),
    .wdata_i (out_wdata),
    .raddr_i (ridx_q),
    .rdata_o (out_rdata)
  );

  // shared precedence and class unit
  itp_prec_unit u_prec (
    .cur_i (c_q),
    .top_i (stk_rdata),
    .cls_o (cls)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    p_d       = p_q;
    sp_d      = sp_q;
    oc_d      = oc_q;
    ridx_d    = ridx_q;
    c_d       = c_q;
    err_d     = err_q;
    in_we     = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = sp_q[SAW-1:0];
    stk_raddr = SAW'(sp_q - SPW'(1));
    out_we    = 1'b0;
    out_wdata = c_q;
    load_out  = 1'b0;
    od_d      = od_q;
    ol_d      = ol_q;
    ou_d      = ou_q;

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          if (cnt_q < CW'(MAX_LEN)) begin
            in_we = 1'b1;
            cnt_d = cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            if (ovf_q || (cnt_q == CW'(MAX_LEN))) begin
              err_d   = STAT_OVERFLOW;
              state_d = S_ERR;
            end else begin
              p_d     = '0;
              sp_d    = '0;
              oc_d    = '0;
              state_d = S_NEXT;
            end
          end
        end
      end

      S_NEXT: begin
        priority if (p_q == n_ext + PW'(2)) begin
          state_d = S_FINISH;
        end else if (p_q == '0) begin
          c_d     = CH_OPEN;
          state_d = S_CHAR;
        end else if (p_q == n_ext + PW'(1)) begin
          c_d     = CH_CLOSE;
          state_d = S_CHAR;
        end else begin
          state_d = S_LATCH;
        end
      end

      S_LATCH: begin
        c_d     = swap_paren(in_rdata);
        state_d = S_CHAR;
      end

      S_CHAR: begin
        priority if (cls.operand) begin
          out_we  = 1'b1;
          oc_d    = oc_q + CW'(1);
          p_d     = p_q + PW'(1);
          state_d = S_NEXT;
        end else if (cls.open) begin
          stk_we  = 1'b1;
          sp_d    = sp_q + SPW'(1);
          p_d     = p_q + PW'(1);
          state_d = S_NEXT;
        end else if (sp_q == '0) begin
          err_d   = STAT_UNBAL;
          state_d = S_ERR;
        end else begin
          state_d = S_TOP;
        end
      end

      S_TOP: begin
        stk_raddr = SAW'(sp_q - SPW'(2));
        if (cls.close) begin
          // unwind to the matching open paren
          if (stk_rdata == CH_OPEN) begin
            sp_d    = sp_q - SPW'(1);
            p_d     = p_q + PW'(1);
            state_d = S_NEXT;
          end else begin
            out_we    = 1'b1;
            out_wdata = stk_rdata;
            oc_d      = oc_q + CW'(1);
            sp_d      = sp_q - SPW'(1);
            if (sp_q == SPW'(1)) begin
              err_d   = STAT_UNBAL;
              state_d = S_ERR;
            end
          end
        end else if (cls.pop) begin
          // pop higher-ranked operators (equal rank too for caret), push when the stack runs dry
          out_we    = 1'b1;
          out_wdata = stk_rdata;
          oc_d      = oc_q + CW'(1);
          sp_d      = sp_q - SPW'(1);
          if (sp_q == SPW'(1)) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            sp_d      = SPW'(1);
            p_d       = p_q + PW'(1);
            state_d   = S_NEXT;
          end
        end else begin
          stk_we  = 1'b1;
          sp_d    = sp_q + SPW'(1);
          p_d     = p_q + PW'(1);
          state_d = S_NEXT;
        end
      end

      S_FINISH: begin
        priority if (sp_q != '0) begin
          err_d   = STAT_UNBAL;
          state_d = S_ERR;
        end else if (oc_q == '0) begin
          err_d   = STAT_OK;
          state_d = S_ERR;
        end else begin
          ridx_d  = AW'(oc_q - CW'(1));
          state_d = S_ORD;
        end
      end

      S_ORD: begin
        state_d = S_OWR;
      end

      S_OWR: begin
        if (out_free) begin
          load_out = 1'b1;
          od_d     = out_rdata;
          ol_d     = (ridx_q == '0);
          ou_d     = STAT_OK;
          if (ridx_q == '0) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            sp_d    = '0;
            oc_d    = '0;
            p_d     = '0;
            state_d = S_IDLE;
          end else begin
            ridx_d  = ridx_q - AW'(1);
            state_d = S_ORD;
          end
        end
      end

      S_ERR: begin
        if (out_free) begin
          load_out = 1'b1;
          od_d     = 8'h00;
          ol_d     = 1'b1;
          ou_d     = err_q;
          cnt_d    = '0;
          ovf_d    = 1'b0;
          sp_d     = '0;
          oc_d     = '0;
          p_d      = '0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (load_out) begin
      ov_d = 1'b1;
    end else if (m_axis_tready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      p_q     <= '0;
      sp_q    <= '0;
      oc_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      p_q     <= p_d;
      sp_q    <= sp_d;
      oc_q    <= oc_d;
      ov_q    <= ov_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    c_q    <= c_d;
    err_q  <= err_d;
    od_q   <= od_d;
    ol_q   <= ol_d;
    ou_q   <= ou_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;
  assign m_axis_tlast  = ol_q;
  assign m_axis_tuser  = ou_q;

endmodule

// File: hdl/itp_checker.sv
`include "assert_macros.svh"

module itp_checker import itp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,   // in_char[7:0]
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,   // out_char[7:0]
  input logic       m_axis_tlast,
  input logic [1:0] m_axis_tuser    // status[1:0]
);

  // stalled result beat holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

  // an error comes as one zero beat that closes the expression
  `ASSERT_HOLDS(a_err_single, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tlast && (m_axis_tdata == 8'h00))

  // a last input beat starts the conversion
  `ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast && (s_axis_tdata == s_axis_tdata), !s_axis_tready)

  // no loading while a result run is still going out
  `ASSERT_HOLDS(a_busy_mid_run, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

endmodule

bind infix_to_prefix_converter_unit itp_checker u_itp_checker (.*);

// File: tb/sv/tb_infix_to_prefix_converter_unit.sv
`timescale 1ns / 100ps

module tb_infix_to_prefix_converter_unit;
  import itp_pkg::*;

  localparam int MAX_LEN = 64;
  // conversion of a full buffer runs with no beat on either side
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = 400;

  typedef logic [7:0] char_q_t[$];

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    status_e    status;
  } prefix_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic [1:0] m_axis_tuser;

  // infix text collected so far and the prefix beats still owed by the block
  logic [7:0]   infix_text[$];
  bit           infix_overflow;
  prefix_beat_t prefix_expect_q[$];
  prefix_beat_t want_beat;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_count = 0;
  int exprs_sent = 0;
  int chars_sent = 0;
  int beats_checked = 0;
  int error_beats = 0;
  int quiet_cycles = 0;

  infix_to_prefix_converter_unit #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),    // in_char[7:0]
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),    // out_char[7:0]
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)     // status[1:0]
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // operator precedence, -1 for anything that is not a known operator
  function automatic int op_rank(logic [7:0] c);
    if (c == CH_CARET) return 3;
    if ((c == CH_STAR) || (c == CH_SLASH)) return 2;
    if ((c == CH_PLUS) || (c == CH_MINUS)) return 1;
    return -1;
  endfunction

  function automatic bit is_operand_char(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
           ((c >= "0") && (c <= "9"));
  endfunction

  // store one accepted char; on the last one convert and queue the prefix beats
  function automatic void predict_prefix_beats(logic [7:0] ch, logic is_last);
    logic [7:0]   opstack[$];
    logic [7:0]   emitted[$];
    logic [7:0]   c;
    logic [7:0]   top;
    status_e      status;
    prefix_beat_t beat;
    int           n;
    int           p;
    int           pc;
    bit           unbal;
    bit           done;
    if (infix_text.size() < MAX_LEN) infix_text.push_back(ch);
    else infix_overflow = 1'b1;
    if (!is_last) return;

    unbal = 1'b0;
    if (infix_overflow) begin
      status = STAT_OVERFLOW;
    end else begin
      // walk the text backwards with parens turned around, wrapped in one extra pair
      n = infix_text.size();
      for (p = 0; (p < n + 2) && !unbal; p++) begin
        if (p == 0) c = CH_OPEN;
        else if (p == n + 1) c = CH_CLOSE;
        else begin
          c = infix_text[n - p];
          if (c == CH_OPEN) c = CH_CLOSE;
          else if (c == CH_CLOSE) c = CH_OPEN;
        end
        if (is_operand_char(c)) begin
          emitted.push_back(c);
        end else if (c == CH_OPEN) begin
          opstack.push_back(c);
        end else if (c == CH_CLOSE) begin
          done = 1'b0;
          while (!done && !unbal) begin
            if (opstack.size() == 0) begin
              unbal = 1'b1;
            end else begin
              top = opstack.pop_back();
              if (top == CH_OPEN) done = 1'b1;
              else emitted.push_back(top);
            end
          end
        end else if (opstack.size() == 0) begin
          unbal = 1'b1;
        end else begin
          // right-assoc caret pops on equal rank, everything else only on higher
          pc = op_rank(c);
          done = 1'b0;
          while (!done && (opstack.size() > 0)) begin
            if ((c == CH_CARET) ? (pc <= op_rank(opstack[$])) : (pc < op_rank(opstack[$])))
              emitted.push_back(opstack.pop_back());
            else
              done = 1'b1;
          end
          opstack.push_back(c);
        end
      end
      if (opstack.size() != 0) unbal = 1'b1;
      status = unbal ? STAT_UNBAL : STAT_OK;
    end

    if ((status != STAT_OK) || (emitted.size() == 0)) begin
      beat.ch = 8'h00;
      beat.is_last = 1'b1;
      beat.status = status;
      prefix_expect_q.push_back(beat);
    end else begin
      for (int i = emitted.size() - 1; i >= 0; i--) begin
        beat.ch = emitted[i];
        beat.is_last = (i == 0);
        beat.status = STAT_OK;
        prefix_expect_q.push_back(beat);
      end
    end
    infix_text.delete();
    infix_overflow = 1'b0;
  endfunction

  // one input beat; called and returning at a falling edge, valid left high
  task automatic send_char(input logic [7:0] ch, input logic is_last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    s_axis_tlast <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_prefix_beats(ch, is_last);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_expression(input char_q_t text);
    foreach (text[i]) send_char(text[i], i == text.size() - 1);
    exprs_sent++;
  endtask

  // hold the input until every owed result beat has been taken
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (prefix_expect_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic char_q_t text_of(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] rand_operand();
    case ($urandom_range(2))
      0:       return 8'("a" + $urandom_range(25));
      1:       return 8'("A" + $urandom_range(25));
      default: return 8'("0" + $urandom_range(9));
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  // balanced expression with random operands, operators and nesting
  function automatic char_q_t make_well_formed(int terms);
    char_q_t q;
    int      depth;
    depth = 0;
    for (int t = 0; t < terms; t++) begin
      if ($urandom_range(3) == 0) begin
        q.push_back(CH_OPEN);
        depth++;
      end
      q.push_back(rand_operand());
      if ((depth > 0) && ($urandom_range(2) == 0)) begin
        q.push_back(CH_CLOSE);
        depth--;
      end
      if (t != terms - 1) q.push_back(rand_operator());
    end
    repeat (depth) q.push_back(CH_CLOSE);
    return q;
  endfunction

  // raw bytes, or a balanced expression with one char replaced or a stray paren inserted
  function automatic char_q_t make_noise();
    char_q_t q;
    if ($urandom_range(1) == 0) begin
      repeat ($urandom_range(8, 1)) begin
        case ($urandom_range(3))
          0:       q.push_back(8'($urandom_range(255)));
          1:       q.push_back(rand_operand());
          2:       q.push_back(rand_operator());
          default: q.push_back($urandom_range(1) ? CH_OPEN : CH_CLOSE);
        endcase
      end
    end else begin
      q = make_well_formed($urandom_range(6, 1));
      case ($urandom_range(2))
        0:       q[$urandom_range(q.size() - 1)] = 8'($urandom_range(255));
        1:       q.insert($urandom_range(q.size()), CH_CLOSE);
        default: q.insert($urandom_range(q.size()), CH_OPEN);
      endcase
    end
    return q;
  endfunction

  // caret chains and every binary operator at mixed ranks
  task automatic test_precedence();
    send_expression(text_of("a^b^c"));
    send_expression(text_of("a-b*c/d+e"));
  endtask

  // lone parens, close before open, operator on empty stack, empty result
  task automatic test_paren_cases();
    send_expression(text_of("("));
    send_expression(text_of(")"));
    send_expression(text_of("+(a"));
    send_expression(text_of("()"));
  endtask

  // null byte and a high byte acting as unranked operators
  task automatic test_raw_bytes();
    char_q_t q;
    q = '{8'h61, 8'h00, 8'h62, 8'hFF, 8'h63};
    send_expression(q);
  endtask

  // a full buffer converts, one char more overflows
  task automatic test_length_limits();
    char_q_t q;
    for (int len = MAX_LEN; len <= MAX_LEN + 1; len++) begin
      q.delete();
      for (int i = 0; i < len; i++) q.push_back((i % 2 == 0) ? rand_operand() : rand_operator());
      send_expression(q);
    end
  endtask

  task automatic test_random_expressions(input int n_chars);
    char_q_t q;
    int      start;
    start = chars_sent;
    while (chars_sent - start < n_chars) begin
      if ($urandom_range(9) == 0) wait_for_results();
      if ($urandom_range(3) == 0) q = make_noise();
      else if ($urandom_range(9) == 0) q = make_well_formed($urandom_range(16, 1));
      else q = make_well_formed($urandom_range(6, 1));
      send_expression(q);
    end
  endtask

  // receiver backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // compare each result beat against the oldest owed beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (m_axis_tuser != STAT_OK) error_beats++;
      if (prefix_expect_q.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected beat char=%02h last=%0b status=%0d", $time,
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
      end else begin
        want_beat = prefix_expect_q.pop_front();
        if (m_axis_tdata !== want_beat.ch) begin
          fail_count++;
          $display("%0t: out_char expected %02h got %02h", $time, want_beat.ch, m_axis_tdata);
        end
        if (m_axis_tlast !== want_beat.is_last) begin
          fail_count++;
          $display("%0t: out_last expected %0b got %0b", $time, want_beat.is_last,
                   m_axis_tlast);
        end
        if (m_axis_tuser !== want_beat.status) begin
          fail_count++;
          $display("%0t: status expected %0d got %0d", $time, want_beat.status,
                   m_axis_tuser);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d result beats still owed", $time,
                 quiet_cycles, prefix_expect_q.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_precedence();
    test_paren_cases();
    test_raw_bytes();
    wait_for_results();

    src_idle_pct = 27;
    sink_stall_pct = 27;
    test_length_limits();

    src_idle_pct = 0;
    sink_stall_pct = 0;
    test_random_expressions(20);
    src_idle_pct = 60;
    test_random_expressions(20);
    src_idle_pct = 0;
    sink_stall_pct = 60;
    test_random_expressions(20);
    src_idle_pct = 27;
    sink_stall_pct = 27;
    test_random_expressions(20);

    s_axis_tvalid <= 1'b0;
    while (prefix_expect_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("converted %0d expressions from %0d chars into %0d result beats", exprs_sent,
             chars_sent, beats_checked);
    $display("%0d error beats (overflow or unbalanced), %0d mismatches", error_beats,
             fail_count);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/itp_pkg.sv
hdl/itp_ram.sv
hdl/itp_prec_unit.sv
hdl/infix_to_prefix_converter_unit.sv
hdl/itp_checker.sv
tb/sv/tb_infix_to_prefix_converter_unit.sv
